// ===== sv/pcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the piecewise contrast stretch.
// No dependencies; used by every module of the block.
package pcs_pkg;

	localparam int unsigned PixW    = 8;
	localparam int unsigned NumCells = 8;
	localparam int unsigned RemW    = 17;
	localparam int unsigned DshW    = 16;
	localparam int unsigned Latency = NumCells + 3;
	localparam int unsigned AddrW   = 4;
	localparam int unsigned DataW   = 32;

	localparam logic [PixW-1:0] MaxLevel = 8'd255;

	// Register indexes, taken from paddr[3:2]
	localparam logic [1:0] RegInLow   = 2'd0;
	localparam logic [1:0] RegInHigh  = 2'd1;
	localparam logic [1:0] RegOutLow  = 2'd2;
	localparam logic [1:0] RegOutHigh = 2'd3;

	typedef struct packed {
		logic [PixW-1:0] in_low;
		logic [PixW-1:0] in_high;
		logic [PixW-1:0] out_low;
		logic [PixW-1:0] out_high;
	} pcs_cfg_t;

	// Data handed from one divider cell to the next
	typedef struct packed {
		logic [RemW-1:0] rem;
		logic [DshW-1:0] dsh;
		logic [PixW-1:0] quo;
		logic [PixW-1:0] base;
		logic            byp;
		logic            last;
	} pcs_cell_t;

endpackage

// ===== sv/pcs_front.sv =====
`timescale 1ns / 1ps
// Segment selection and span multiply ahead of the divider chain.
// Depends on pcs_pkg.
module pcs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pcs_pkg::pcs_cfg_t      cfg,
	input  logic                   take,
	input  logic [pcs_pkg::PixW-1:0] pixel,
	input  logic                   last,
	output logic                   vld,
	output pcs_pkg::pcs_cell_t     head
);
	import pcs_pkg::*;

	typedef struct packed {
		logic [PixW-1:0] base;
		logic [PixW-1:0] span;
		logic [PixW-1:0] diff;
		logic [PixW-1:0] den;
		logic            byp;
		logic            last;
	} pcs_seg_t;

	pcs_seg_t        seg_d;
	pcs_seg_t        seg_s1;
	logic            vld_s1;
	logic            vld_s2;
	logic [2*PixW-1:0] num_s2;
	logic [PixW-1:0] den_s2;
	logic [PixW-1:0] base_s2;
	logic            byp_s2;
	logic            last_s2;
	logic            cfg_ok;
	logic [PixW-1:0] a;
	logic [PixW-1:0] b;
	logic [PixW-1:0] lo;
	logic [PixW-1:0] hi;

	assign cfg_ok = (cfg.in_low < cfg.in_high) && (cfg.out_low < cfg.out_high);

	always_comb begin
		if (pixel <= cfg.in_low) begin
			a  = '0;
			b  = cfg.in_low;
			lo = '0;
			hi = cfg.out_low;
		end else if (pixel <= cfg.in_high) begin
			a  = cfg.in_low;
			b  = cfg.in_high;
			lo = cfg.out_low;
			hi = cfg.out_high;
		end else begin
			a  = cfg.in_high;
			b  = MaxLevel;
			lo = cfg.out_high;
			hi = MaxLevel;
		end
		seg_d.last = last;
		seg_d.byp  = !cfg_ok;
		seg_d.diff = pixel - a;
		if (!cfg_ok) begin
			// pass the pixel through as the base with a zero span
			seg_d.base = pixel;
			seg_d.span = '0;
			seg_d.den  = 8'd1;
		end else if (b == a) begin
			// zero-width first segment: result is the segment base
			seg_d.base = lo;
			seg_d.span = '0;
			seg_d.den  = 8'd1;
		end else begin
			seg_d.base = lo;
			seg_d.span = hi - lo;
			seg_d.den  = b - a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		seg_s1  <= seg_d;
		num_s2  <= seg_s1.span * seg_s1.diff;
		den_s2  <= seg_s1.den;
		base_s2 <= seg_s1.base;
		byp_s2  <= seg_s1.byp;
		last_s2 <= seg_s1.last;
	end

	// dividend 2*num + den, divisor 2*den aligned to the top quotient bit
	always_comb begin
		vld       = vld_s2;
		head.rem  = {num_s2, 1'b0} + {{(RemW-PixW){1'b0}}, den_s2};
		head.dsh  = {den_s2, {(DshW-PixW){1'b0}}};
		head.quo  = '0;
		head.base = base_s2;
		head.byp  = byp_s2;
		head.last = last_s2;
	end

endmodule

// ===== sv/pcs_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring-division cell: resolves one quotient bit per pass.
// Depends on pcs_pkg.
module pcs_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_vld,
	input  pcs_pkg::pcs_cell_t up,
	output logic               dn_vld,
	output pcs_pkg::pcs_cell_t dn
);
	import pcs_pkg::*;

	pcs_cell_t       nxt;
	logic            fits;
	logic [RemW-1:0] dsh_ext;
	pcs_cell_t       dn_q;
	logic            dn_vld_q;

	assign dsh_ext = {1'b0, up.dsh};
	assign fits    = up.rem >= dsh_ext;

	always_comb begin
		nxt      = up;
		nxt.rem  = fits ? (up.rem - dsh_ext) : up.rem;
		nxt.dsh  = {1'b0, up.dsh[DshW-1:1]};
		nxt.quo  = {up.quo[PixW-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_vld_q <= 1'b0;
			dn_q     <= '0;
		end else begin
			dn_vld_q <= up_vld;
			dn_q     <= nxt;
		end
	end

	assign dn_vld = dn_vld_q;
	assign dn     = dn_q;

	// remainder stays below the divisor just tried
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dn_vld |-> (dn.rem < {dn.dsh, 1'b0}))
		else $error("remainder not reduced below divisor");

endmodule

// ===== sv/piecewise_contrast_stretch.sv =====
`timescale 1ns / 1ps
// Piecewise linear contrast stretch: top level with register port and divider chain.
// Depends on pcs_pkg, pcs_front and pcs_div_cell.
//
// Takes one pixel request every clock: busy stays low, so start may be held high
// indefinitely. Each pixel's result appears on pixel_out, bypassed and last_out for
// one cycle with done high, once it has passed the segment selection and span
// multiply registers, the eight cells of the divider chain with one quotient bit
// each and one output register. Results come out in request order and
// the receiver must take them in that cycle. Write the breakpoint registers only
// while no pixel is in flight.
module piecewise_contrast_stretch (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [pcs_pkg::AddrW-1:0] paddr,
	input  logic [pcs_pkg::DataW-1:0] pwdata,
	output logic [pcs_pkg::DataW-1:0] prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic [pcs_pkg::PixW-1:0]  pixel_in,
	input  logic                      last_in,
	output logic                      done,
	output logic [pcs_pkg::PixW-1:0]  pixel_out,
	output logic                      bypassed,
	output logic                      last_out
);
	import pcs_pkg::*;

	pcs_cfg_t        cfg_q;
	logic            wr_en;
	logic [1:0]      reg_idx;
	logic [PixW-1:0] rd_val;
	logic            take;
	logic            chain_vld [NumCells+1];
	pcs_cell_t       chain     [NumCells+1];
	logic            done_q;
	logic [PixW-1:0] pixel_out_q;
	logic            bypassed_q;
	logic            last_out_q;
	pcs_cell_t       tail;
	logic [PixW:0]   sum;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign take    = start && !busy;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_low   <= '0;
			cfg_q.in_high  <= MaxLevel;
			cfg_q.out_low  <= '0;
			cfg_q.out_high <= MaxLevel;
		end else if (wr_en) begin
			unique case (reg_idx)
				RegInLow:   cfg_q.in_low   <= pwdata[PixW-1:0];
				RegInHigh:  cfg_q.in_high  <= pwdata[PixW-1:0];
				RegOutLow:  cfg_q.out_low  <= pwdata[PixW-1:0];
				RegOutHigh: cfg_q.out_high <= pwdata[PixW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			RegInLow:   rd_val = cfg_q.in_low;
			RegInHigh:  rd_val = cfg_q.in_high;
			RegOutLow:  rd_val = cfg_q.out_low;
			RegOutHigh: rd_val = cfg_q.out_high;
			default:    rd_val = '0;
		endcase
	end

	assign prdata = {{(DataW-PixW){1'b0}}, rd_val};

	pcs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.take   (take),
		.pixel  (pixel_in),
		.last   (last_in),
		.vld    (chain_vld[0]),
		.head   (chain[0])
	);

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		pcs_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.up_vld (chain_vld[i]),
			.up     (chain[i]),
			.dn_vld (chain_vld[i+1]),
			.dn     (chain[i+1])
		);
	end

	assign tail = chain[NumCells];
	assign sum  = {1'b0, tail.base} + {1'b0, tail.quo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain_vld[NumCells];
		end
	end

	always_ff @(posedge clk) begin
		pixel_out_q <= sum[PixW-1:0];
		bypassed_q  <= tail.byp;
		last_out_q  <= tail.last;
	end

	assign done      = done_q;
	assign pixel_out = pixel_out_q;
	assign bypassed  = bypassed_q;
	assign last_out  = last_out_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, Latency))
		else $error("result without a matching request");

	a_bypass_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bypassed) |-> (pixel_out == $past(pixel_in, Latency)))
		else $error("bypassed pixel altered");

	a_last_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_out == $past(last_in, Latency)))
		else $error("last flag out of step with pixel");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_contrast_stretch: APB curve setup, pixel requests.
// Depends on pcs_pkg and the RTL of the block; predicts each pixel with a local curve model.
module tb;

	import pcs_pkg::*;

	localparam int unsigned CycleLimit  = 400000;
	localparam int unsigned RandPhases  = 16;
	localparam int unsigned PhaseItems  = 97;
	localparam int unsigned MaxReports  = 40;

	typedef struct packed {
		logic [PixW-1:0] pixel;
		logic            last;
	} pix_req_t;

	typedef struct packed {
		logic [PixW-1:0] pixel;
		logic            bypassed;
		logic            last;
	} pix_result_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [AddrW-1:0]  paddr   = '0;
	logic [DataW-1:0]  pwdata  = '0;
	logic [DataW-1:0]  prdata;
	logic              pready;
	logic              start    = 1'b0;
	logic              busy;
	logic [PixW-1:0]   pixel_in = '0;
	logic              last_in  = 1'b0;
	logic              done;
	logic [PixW-1:0]   pixel_out;
	logic              bypassed;
	logic              last_out;

	pcs_cfg_t          curve = 32'h00FF_00FF;
	pix_req_t          pixel_backlog[$];
	pix_result_t       expected_pixels[$];
	pix_req_t          next_req;
	logic              req_taken = 1'b0;
	int unsigned       idle_pct = 0;
	int unsigned       cycle_cnt = 0;
	int unsigned       error_cnt = 0;
	int unsigned       pixels_checked = 0;
	int unsigned       bypass_cnt = 0;
	int unsigned       curves_loaded = 0;

	piecewise_contrast_stretch u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.start     (start),
		.busy      (busy),
		.pixel_in  (pixel_in),
		.last_in   (last_in),
		.done      (done),
		.pixel_out (pixel_out),
		.bypassed  (bypassed),
		.last_out  (last_out)
	);

	always #2 clk = ~clk;

	// lo + (span_out * (p - a)) / (b - a), rounded half up
	function automatic int unsigned seg_value(input int unsigned p, input int unsigned a,
			input int unsigned b, input int unsigned lo, input int unsigned hi);
		int unsigned den;
		int unsigned num;
		den = b - a;
		num = (hi - lo) * (p - a);
		return lo + (2 * num + den) / (2 * den);
	endfunction

	function automatic pix_result_t stretch_pixel(input logic [PixW-1:0] pix, input logic lst);
		pix_result_t r;
		r.last     = lst;
		r.bypassed = 1'b0;
		if (curve.in_low >= curve.in_high || curve.out_low >= curve.out_high) begin
			r.pixel    = pix;
			r.bypassed = 1'b1;
		end else if (pix <= curve.in_low) begin
			// zero-width first segment: black stays black
			if (curve.in_low == 0)
				r.pixel = '0;
			else
				r.pixel = PixW'(seg_value(pix, 0, curve.in_low, 0, curve.out_low));
		end else if (pix <= curve.in_high) begin
			r.pixel = PixW'(seg_value(pix, curve.in_low, curve.in_high,
				curve.out_low, curve.out_high));
		end else begin
			r.pixel = PixW'(seg_value(pix, curve.in_high, MaxLevel, curve.out_high, MaxLevel));
		end
		return r;
	endfunction

	// Driver: hold an unaccepted request, otherwise issue or idle at random
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !req_taken) begin
		end else if (pixel_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
			next_req = pixel_backlog.pop_front();
			start    <= 1'b1;
			pixel_in <= next_req.pixel;
			last_in  <= next_req.last;
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: predict on accepted requests, check on every done strobe
	always @(posedge clk) begin
		pix_result_t want;
		req_taken <= start && !busy;
		if (arst_n) begin
			if (start && !busy)
				expected_pixels.push_back(stretch_pixel(pixel_in, last_in));
			if (done === 1'b1) begin
				if (expected_pixels.size() == 0) begin
					error_cnt++;
					if (error_cnt <= MaxReports)
						$display("%0t: unexpected result pixel_out=%0d bypassed=%b last_out=%b",
							$time, pixel_out, bypassed, last_out);
				end else begin
					want = expected_pixels.pop_front();
					pixels_checked++;
					if (bypassed === 1'b1)
						bypass_cnt++;
					if (pixel_out !== want.pixel || bypassed !== want.bypassed ||
							last_out !== want.last) begin
						error_cnt++;
						if (error_cnt <= MaxReports)
							$display("%0t: mismatch expected pixel_out=%0d bypassed=%b last_out=%b, got pixel_out=%0d bypassed=%b last_out=%b",
								$time, want.pixel, want.bypassed, want.last,
								pixel_out, bypassed, last_out);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("%0t: timeout, %0d results still expected", $time, expected_pixels.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [PixW-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom_range(24'hFF_FFFF)), val};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		case (idx)
			RegInLow:   curve.in_low   = val;
			RegInHigh:  curve.in_high  = val;
			RegOutLow:  curve.out_low  = val;
			RegOutHigh: curve.out_high = val;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic load_curve(input pcs_cfg_t c);
		write_reg(RegInLow, c.in_low);
		write_reg(RegInHigh, c.in_high);
		write_reg(RegOutLow, c.out_low);
		write_reg(RegOutHigh, c.out_high);
		curves_loaded++;
	endtask

	task automatic queue_pixel(input int unsigned p, input logic lst);
		pixel_backlog.push_back('{pixel: PixW'(p), last: lst});
	endtask

	// Let every queued request out and every result back, then let the pipe empty
	task automatic wait_drained;
		while (pixel_backlog.size() != 0 || start || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (Latency + 2) @(posedge clk);
	endtask

	// Favor pixels around the breakpoints and the ends of the range
	function automatic int unsigned pick_pixel;
		int v;
		case ($urandom_range(7))
			0: v = int'(curve.in_low) + int'($urandom_range(2)) - 1;
			1: v = int'(curve.in_high) + int'($urandom_range(2)) - 1;
			2: v = $urandom_range(1) ? 255 : 0;
			default: v = $urandom_range(255);
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v;
	endfunction

	function automatic pcs_cfg_t random_curve;
		pcs_cfg_t c;
		if ($urandom_range(3) == 0) begin
			c = $urandom();
		end else begin
			c.in_low   = PixW'($urandom_range(254));
			c.in_high  = PixW'($urandom_range(255, c.in_low + 1));
			c.out_low  = PixW'($urandom_range(254));
			c.out_high = PixW'($urandom_range(255, c.out_low + 1));
		end
		return c;
	endfunction

	initial begin
		pcs_cfg_t    corner_curves[7];
		int unsigned idle_levels[4];
		corner_curves = '{32'h00FF_00FF, 32'h0001_00FF, 32'hFEFF_0001, 32'h00FF_FEFF,
			32'h01FE_01FE, 32'hFFFF_FFFF, 32'h0000_0000};
		idle_levels = '{0, 73, 0, 18};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset curve is the identity
		queue_pixel(0, 1'b0);
		queue_pixel(1, 1'b1);
		queue_pixel(128, 1'b0);
		queue_pixel(255, 1'b1);
		wait_drained();

		// Three real segments, pixels on and around each breakpoint
		load_curve(32'h3CC8_1EDC);
		queue_pixel(0, 1'b0);
		queue_pixel(59, 1'b0);
		queue_pixel(60, 1'b0);
		queue_pixel(61, 1'b0);
		queue_pixel(199, 1'b0);
		queue_pixel(200, 1'b0);
		queue_pixel(201, 1'b0);
		queue_pixel(255, 1'b1);
		wait_drained();

		// Zero-width first segment
		load_curve(32'h0064_32C8);
		queue_pixel(0, 1'b0);
		queue_pixel(1, 1'b0);
		queue_pixel(100, 1'b0);
		queue_pixel(101, 1'b1);
		wait_drained();

		// Equal input breakpoints, then equal output levels: pass through
		load_curve(32'h6464_0A14);
		queue_pixel(0, 1'b0);
		queue_pixel(77, 1'b0);
		queue_pixel(255, 1'b1);
		wait_drained();
		load_curve(32'h0A14_1E1E);
		queue_pixel(200, 1'b1);
		queue_pixel(15, 1'b0);
		wait_drained();

		for (int ph = 0; ph < RandPhases; ph++) begin
			load_curve(ph < 7 ? corner_curves[ph] : random_curve());
			idle_pct = idle_levels[ph % 4];
			for (int n = 0; n < PhaseItems; n++)
				queue_pixel(pick_pixel(), $urandom_range(7) == 0);
			wait_drained();
		end
		idle_pct = 0;

		$display("Checked %0d pixels over %0d loaded curves, %0d of them passed through unchanged.",
			pixels_checked, curves_loaded, bypass_cnt);
		if (error_cnt == 0 && expected_pixels.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d errors, %0d results missing", error_cnt, expected_pixels.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
